// ===== rtl/core/pcm_pkg.sv =====
package pcm_pkg;

   localparam logic [2:0] OP_OPEN    = 3'd0;
   localparam logic [2:0] OP_CLOSE   = 3'd1;
   localparam logic [2:0] OP_WRITE   = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_RELEASE = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FULL_TABLE = 3'd1;
   localparam logic [2:0] ST_INVALID    = 3'd2;
   localparam logic [2:0] ST_BUF_FULL   = 3'd3;
   localparam logic [2:0] ST_WAIT       = 3'd4;
   localparam logic [2:0] ST_EOD        = 3'd5;

   localparam logic [7:0] HANDLE_BASE = 8'd3;

   typedef struct packed {
      logic [2:0] status;
      logic       store_write;
      logic       store_read;
      logic       set_rd_wait;
      logic       clr_rd_wait;
      logic       set_wr_wait;
      logic       clr_wr_wait;
      logic       wake;
   } pcm_verdict_type;

endpackage

// ===== rtl/core/pipe_channel_manager_unit.sv =====
// Pipe channel table with one byte ring buffer per channel. Each request
// transaction produces exactly one response transaction. The block takes one
// request at a time: close and write pass through S_CHAN and then S_RESP, and
// read reads the channel record and then, for a byte, the byte store (S_CHAN,
// S_BYTE, S_RESP); open checks one table entry per cycle in S_OSCAN, then
// updates the record of a joined channel in S_OJOIN; release reads (S_RREAD)
// and then checks (S_RCHECK) each channel record. Channel records and buffer
// bytes live in two synchronous memories. A new request is taken while the
// previous response waits.
module pipe_channel_manager_unit #(
   parameter int NUM_CHANNELS = 16,
   parameter int BUF_BYTES    = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: pid[15:0], mode[16], handle[24:17], data_in[32:25].
   input  logic [39:0] req_tdata,
   // Fields from bit 0: op[2:0].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: status[2:0], handle_out[7:3], data_out[15:8],
   // wake_valid[16], wake_pid[32:17].
   output logic [39:0] rsp_tdata
);

   localparam int SW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PW = $clog2(BUF_BYTES);
   localparam int FW = $clog2(BUF_BYTES + 1);
   localparam int CW = $clog2(NUM_CHANNELS + 1);
   localparam int AW = $clog2(NUM_CHANNELS * BUF_BYTES);
   localparam int RW = 32 + 2 * PW + FW;
   localparam logic [SW-1:0] IDX_LAST = SW'(NUM_CHANNELS - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(NUM_CHANNELS);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_CHAN   = 8'b00000010,
      S_OSCAN  = 8'b00000100,
      S_OJOIN  = 8'b00001000,
      S_RREAD  = 8'b00010000,
      S_RCHECK = 8'b00100000,
      S_BYTE   = 8'b01000000,
      S_RESP   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] idx_ff, idx_in, slot_ff, slot_in, free_ff, free_in;
   logic found_ff, found_in, hvalid_ff, hvalid_in, mode_ff, mode_in;
   logic [2:0] op_ff, op_in;
   logic [15:0] pid_ff, pid_in;
   logic [7:0] din_ff, din_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NUM_CHANNELS-1:0] used_ff, used_in, rp_ff, rp_in, wp_ff, wp_in;
   logic [NUM_CHANNELS-1:0] rw_ff, rw_in, ww_ff, ww_in;
   logic [2:0] res_status_ff, res_status_in;
   logic [4:0] res_hout_ff, res_hout_in;
   logic [7:0] res_dout_ff, res_dout_in;
   logic res_wv_ff, res_wv_in;
   logic [15:0] res_wpid_ff, res_wpid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [32:0] rsp_data_ff, rsp_data_in;

   logic [RW-1:0] rec_mem [NUM_CHANNELS];
   logic [RW-1:0] rec_q, rec_wd;
   logic [SW-1:0] rec_ra, rec_wa;
   logic rec_we;
   logic [7:0] store_mem [NUM_CHANNELS * BUF_BYTES];
   logic [7:0] store_q;
   logic [AW-1:0] store_addr;
   logic store_we, store_re;

   logic [15:0] q_rid, q_wid;
   logic [PW-1:0] q_head, q_tail, n_head, n_tail;
   logic [FW-1:0] q_fill, n_fill;
   logic [7:0] req_handle, handle_off;
   logic handle_ok, join_hit, cur_free, rd_keep, wr_keep;
   logic [SW-1:0] new_slot;
   pcm_pkg::pcm_verdict_type verdict;

   assign {q_rid, q_wid, q_head, q_tail, q_fill} = rec_q;
   assign req_handle = req_tdata[24:17];
   assign handle_off = req_handle - pcm_pkg::HANDLE_BASE;
   assign handle_ok  = (req_handle >= pcm_pkg::HANDLE_BASE) &&
                       (handle_off < 8'(NUM_CHANNELS));
   assign join_hit = used_ff[idx_ff] && (mode_ff ? !wp_ff[idx_ff] : !rp_ff[idx_ff]);
   assign cur_free = !used_ff[idx_ff];
   assign new_slot = found_ff ? free_ff : idx_ff;
   assign rd_keep  = rp_ff[idx_ff] && (q_rid != pid_ff);
   assign wr_keep  = wp_ff[idx_ff] && (q_wid != pid_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   assign store_addr = AW'(slot_ff) * AW'(BUF_BYTES) +
                       AW'(op_ff == pcm_pkg::OP_WRITE ? q_head : q_tail);

   pcm_chan_update #(
      .BUF_BYTES(BUF_BYTES)
   ) u_update (
      .is_write  (op_ff == pcm_pkg::OP_WRITE),
      .chan_valid(hvalid_ff && used_ff[slot_ff]),
      .rd_present(rp_ff[slot_ff]),
      .wr_present(wp_ff[slot_ff]),
      .rd_waiting(rw_ff[slot_ff]),
      .wr_waiting(ww_ff[slot_ff]),
      .head      (q_head),
      .tail      (q_tail),
      .fill      (q_fill),
      .head_next (n_head),
      .tail_next (n_tail),
      .fill_next (n_fill),
      .verdict   (verdict)
   );

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      free_in = free_ff;
      found_in = found_ff;
      hvalid_in = hvalid_ff;
      mode_in = mode_ff;
      op_in = op_ff;
      pid_in = pid_ff;
      din_in = din_ff;
      count_in = count_ff;
      used_in = used_ff;
      rp_in = rp_ff;
      wp_in = wp_ff;
      rw_in = rw_ff;
      ww_in = ww_ff;
      res_status_in = res_status_ff;
      res_hout_in = res_hout_ff;
      res_dout_in = res_dout_ff;
      res_wv_in = res_wv_ff;
      res_wpid_in = res_wpid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rec_ra = idx_ff;
      rec_we = 1'b0;
      rec_wa = slot_ff;
      rec_wd = rec_q;
      store_we = 1'b0;
      store_re = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            rec_ra = handle_off[SW-1:0];
            if (req_tvalid) begin
               op_in = req_tuser;
               pid_in = req_tdata[15:0];
               mode_in = req_tdata[16];
               din_in = req_tdata[32:25];
               hvalid_in = handle_ok;
               slot_in = handle_off[SW-1:0];
               idx_in = '0;
               found_in = 1'b0;
               res_status_in = pcm_pkg::ST_OK;
               res_hout_in = '0;
               res_dout_in = '0;
               res_wv_in = 1'b0;
               res_wpid_in = '0;
               if (req_tuser == pcm_pkg::OP_OPEN) begin
                  if (count_ff >= COUNT_MAX) begin
                     res_status_in = pcm_pkg::ST_FULL_TABLE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_OSCAN;
                  end
               end else if (req_tuser == pcm_pkg::OP_RELEASE) begin
                  state_in = S_RREAD;
               end else begin
                  state_in = S_CHAN;
               end
            end
         end
         S_CHAN: begin
            state_in = S_RESP;
            case (op_ff)
               pcm_pkg::OP_CLOSE: begin
                  if (hvalid_ff && used_ff[slot_ff]) begin
                     used_in[slot_ff] = 1'b0;
                     rp_in[slot_ff] = 1'b0;
                     wp_in[slot_ff] = 1'b0;
                     rw_in[slot_ff] = 1'b0;
                     ww_in[slot_ff] = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                  end else begin
                     res_status_in = pcm_pkg::ST_INVALID;
                  end
               end
               pcm_pkg::OP_WRITE, pcm_pkg::OP_READ: begin
                  res_status_in = verdict.status;
                  res_wv_in = verdict.wake;
                  if (verdict.wake) begin
                     res_wpid_in = (op_ff == pcm_pkg::OP_WRITE) ? q_rid : q_wid;
                  end
                  if (verdict.set_rd_wait) rw_in[slot_ff] = 1'b1;
                  if (verdict.clr_rd_wait) rw_in[slot_ff] = 1'b0;
                  if (verdict.set_wr_wait) ww_in[slot_ff] = 1'b1;
                  if (verdict.clr_wr_wait) ww_in[slot_ff] = 1'b0;
                  if (verdict.store_write || verdict.store_read) begin
                     rec_we = 1'b1;
                     rec_wd = {q_rid, q_wid, n_head, n_tail, n_fill};
                  end
                  store_we = verdict.store_write;
                  store_re = verdict.store_read;
                  if (verdict.store_read) begin
                     state_in = S_BYTE;
                  end
               end
               default: begin
                  res_status_in = pcm_pkg::ST_INVALID;
               end
            endcase
         end
         S_BYTE: begin
            res_dout_in = store_q;
            state_in = S_RESP;
         end
         S_OSCAN: begin
            if (cur_free && !found_ff) begin
               free_in = idx_ff;
               found_in = 1'b1;
            end
            if (join_hit) begin
               slot_in = idx_ff;
               if (mode_ff) begin
                  wp_in[idx_ff] = 1'b1;
               end else begin
                  rp_in[idx_ff] = 1'b1;
               end
               res_hout_in = 5'(idx_ff) + 5'(pcm_pkg::HANDLE_BASE);
               state_in = S_OJOIN;
            end else if (idx_ff == IDX_LAST) begin
               if (found_ff || cur_free) begin
                  used_in[new_slot] = 1'b1;
                  rp_in[new_slot] = !mode_ff;
                  wp_in[new_slot] = mode_ff;
                  rw_in[new_slot] = 1'b0;
                  ww_in[new_slot] = 1'b0;
                  count_in = count_ff + CW'(1);
                  rec_we = 1'b1;
                  rec_wa = new_slot;
                  rec_wd = {(mode_ff ? 16'd0 : pid_ff), (mode_ff ? pid_ff : 16'd0),
                            {PW{1'b0}}, {PW{1'b0}}, {FW{1'b0}}};
                  res_hout_in = 5'(new_slot) + 5'(pcm_pkg::HANDLE_BASE);
               end else begin
                  res_status_in = pcm_pkg::ST_FULL_TABLE;
               end
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         S_OJOIN: begin
            rec_we = 1'b1;
            rec_wd = mode_ff ? {q_rid, pid_ff, q_head, q_tail, q_fill}
                             : {pid_ff, q_wid, q_head, q_tail, q_fill};
            state_in = S_RESP;
         end
         S_RREAD: begin
            state_in = S_RCHECK;
         end
         S_RCHECK: begin
            rp_in[idx_ff] = rd_keep;
            wp_in[idx_ff] = wr_keep;
            if (used_ff[idx_ff] && !rd_keep && !wr_keep) begin
               used_in[idx_ff] = 1'b0;
               rw_in[idx_ff] = 1'b0;
               ww_in[idx_ff] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
            end
            if (idx_ff == IDX_LAST) begin
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + SW'(1);
               state_in = S_RREAD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {res_wpid_ff, res_wv_ff, res_dout_ff, res_hout_ff,
                              res_status_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_q <= rec_mem[rec_ra];
      if (rec_we) begin
         rec_mem[rec_wa] <= rec_wd;
      end
      if (store_we) begin
         store_mem[store_addr] <= din_ff;
      end
      if (store_re) begin
         store_q <= store_mem[store_addr];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      free_ff <= free_in;
      found_ff <= found_in;
      hvalid_ff <= hvalid_in;
      mode_ff <= mode_in;
      op_ff <= op_in;
      pid_ff <= pid_in;
      din_ff <= din_in;
      res_status_ff <= res_status_in;
      res_hout_ff <= res_hout_in;
      res_dout_ff <= res_dout_in;
      res_wv_ff <= res_wv_in;
      res_wpid_ff <= res_wpid_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         used_ff <= '0;
         rp_ff <= '0;
         wp_ff <= '0;
         rw_ff <= '0;
         ww_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff <= used_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
         rw_ff <= rw_in;
         ww_ff <= ww_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/pcm_chan_update.sv =====
module pcm_chan_update #(
   parameter int BUF_BYTES = 256
) (
   input  logic                               is_write,
   input  logic                               chan_valid,
   input  logic                               rd_present,
   input  logic                               wr_present,
   input  logic                               rd_waiting,
   input  logic                               wr_waiting,
   input  logic [$clog2(BUF_BYTES)-1:0]       head,
   input  logic [$clog2(BUF_BYTES)-1:0]       tail,
   input  logic [$clog2(BUF_BYTES+1)-1:0]     fill,
   output logic [$clog2(BUF_BYTES)-1:0]       head_next,
   output logic [$clog2(BUF_BYTES)-1:0]       tail_next,
   output logic [$clog2(BUF_BYTES+1)-1:0]     fill_next,
   output pcm_pkg::pcm_verdict_type           verdict
);

   localparam int PW = $clog2(BUF_BYTES);
   localparam int FW = $clog2(BUF_BYTES + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(BUF_BYTES - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(BUF_BYTES);

   always_comb begin
      verdict   = '0;
      verdict.status = pcm_pkg::ST_OK;
      head_next = head;
      tail_next = tail;
      fill_next = fill;
      if (is_write) begin
         if (!chan_valid || !wr_present) begin
            verdict.status = pcm_pkg::ST_INVALID;
         end else if (fill >= FILL_MAX) begin
            verdict.status = pcm_pkg::ST_BUF_FULL;
            verdict.set_wr_wait = 1'b1;
         end else begin
            verdict.store_write = 1'b1;
            head_next = (head == PTR_LAST) ? '0 : head + PW'(1);
            fill_next = fill + FW'(1);
            verdict.clr_rd_wait = 1'b1;
            verdict.wake = rd_waiting && rd_present;
         end
      end else begin
         if (!chan_valid || !rd_present) begin
            verdict.status = pcm_pkg::ST_INVALID;
         end else if (fill == '0) begin
            if (wr_present) begin
               verdict.status = pcm_pkg::ST_WAIT;
               verdict.set_rd_wait = 1'b1;
            end else begin
               verdict.status = pcm_pkg::ST_EOD;
            end
         end else begin
            verdict.store_read = 1'b1;
            tail_next = (tail == PTR_LAST) ? '0 : tail + PW'(1);
            fill_next = fill - FW'(1);
            verdict.clr_wr_wait = 1'b1;
            verdict.wake = wr_waiting && wr_present;
         end
      end
   end

endmodule

// ===== verif/pipe_channel_manager_unit_test.sv =====
module pipe_channel_manager_unit_test;
   import pcm_pkg::*;

   localparam int NCH = 16;
   localparam int BUFB = 256;
   localparam int RANDOM_ITEMS = 1180;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] pid;
      logic        mode;
      logic [7:0]  handle;
      logic [7:0]  data_in;
   } pipe_req_t;

   typedef struct packed {
      logic [15:0] wake_pid;
      logic        wake_valid;
      logic [7:0]  data_out;
      logic [4:0]  handle_out;
      logic [2:0]  status;
   } pipe_rsp_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   pipe_channel_manager_unit #(.NUM_CHANNELS(NCH), .BUF_BYTES(BUFB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Shadow of the channel table.
   logic        ch_used [NCH];
   logic [15:0] ch_rd_id [NCH];
   logic        ch_rd_on [NCH];
   logic [15:0] ch_wr_id [NCH];
   logic        ch_wr_on [NCH];
   int          ch_head [NCH];
   int          ch_tail [NCH];
   int          ch_fill [NCH];
   logic        ch_rd_wait [NCH];
   logic        ch_wr_wait [NCH];
   int          chan_count;
   logic [7:0]  ring [NCH][BUFB];

   pipe_req_t   pending_reqs[$];
   pipe_rsp_t   expected_rsps[$];
   int          fail_count;
   longint      cycle_count;
   logic        stimulus_done;
   logic        quiet_phase;
   logic        hold_rsp;
   int          idle_pct;

   function automatic int slot_from_handle(logic [7:0] h);
      if (h < HANDLE_BASE || int'(h - HANDLE_BASE) >= NCH) return -1;
      if (!ch_used[h - HANDLE_BASE]) return -1;
      return int'(h - HANDLE_BASE);
   endfunction

   function automatic void drop_channel(int s);
      ch_used[s] = 0;
      ch_rd_on[s] = 0;
      ch_wr_on[s] = 0;
      ch_rd_wait[s] = 0;
      ch_wr_wait[s] = 0;
      if (chan_count > 0) chan_count--;
   endfunction

   function automatic pipe_rsp_t channel_outcome(pipe_req_t r);
      pipe_rsp_t o;
      int s;
      o = '0;
      o.status = ST_OK;
      case (r.op)
         OP_OPEN: begin
            if (chan_count >= NCH) begin
               o.status = ST_FULL_TABLE;
            end else begin
               s = -1;
               for (int i = 0; i < NCH && s < 0; i++) begin
                  if (!ch_used[i]) continue;
                  if (!r.mode && !ch_rd_on[i]) begin
                     ch_rd_on[i] = 1; ch_rd_id[i] = r.pid; s = i;
                  end else if (r.mode && !ch_wr_on[i]) begin
                     ch_wr_on[i] = 1; ch_wr_id[i] = r.pid; s = i;
                  end
               end
               for (int i = 0; i < NCH && s < 0; i++) begin
                  if (!ch_used[i]) begin
                     s = i;
                     ch_used[i] = 1;
                     ch_head[i] = 0; ch_tail[i] = 0; ch_fill[i] = 0;
                     ch_rd_wait[i] = 0; ch_wr_wait[i] = 0;
                     ch_rd_on[i] = !r.mode; ch_wr_on[i] = r.mode;
                     ch_rd_id[i] = r.mode ? 16'd0 : r.pid;
                     ch_wr_id[i] = r.mode ? r.pid : 16'd0;
                     chan_count++;
                  end
               end
               if (s < 0) o.status = ST_FULL_TABLE;
               else o.handle_out = 5'(s + HANDLE_BASE);
            end
         end
         OP_CLOSE: begin
            s = slot_from_handle(r.handle);
            if (s < 0) o.status = ST_INVALID;
            else drop_channel(s);
         end
         OP_WRITE: begin
            s = slot_from_handle(r.handle);
            if (s < 0 || !ch_wr_on[s]) begin
               o.status = ST_INVALID;
            end else if (ch_fill[s] >= BUFB) begin
               o.status = ST_BUF_FULL;
               ch_wr_wait[s] = 1;
            end else begin
               ring[s][ch_head[s]] = r.data_in;
               ch_head[s] = (ch_head[s] + 1) % BUFB;
               ch_fill[s]++;
               if (ch_rd_wait[s]) begin
                  ch_rd_wait[s] = 0;
                  if (ch_rd_on[s]) begin
                     o.wake_valid = 1; o.wake_pid = ch_rd_id[s];
                  end
               end
            end
         end
         OP_READ: begin
            s = slot_from_handle(r.handle);
            if (s < 0 || !ch_rd_on[s]) begin
               o.status = ST_INVALID;
            end else if (ch_fill[s] == 0) begin
               if (!ch_wr_on[s]) o.status = ST_EOD;
               else begin
                  o.status = ST_WAIT; ch_rd_wait[s] = 1;
               end
            end else begin
               o.data_out = ring[s][ch_tail[s]];
               ch_tail[s] = (ch_tail[s] + 1) % BUFB;
               ch_fill[s]--;
               if (ch_wr_wait[s]) begin
                  ch_wr_wait[s] = 0;
                  if (ch_wr_on[s]) begin
                     o.wake_valid = 1; o.wake_pid = ch_wr_id[s];
                  end
               end
            end
         end
         OP_RELEASE: begin
            for (int i = 0; i < NCH; i++) begin
               if (ch_wr_on[i] && ch_wr_id[i] == r.pid) ch_wr_on[i] = 0;
               if (ch_rd_on[i] && ch_rd_id[i] == r.pid) ch_rd_on[i] = 0;
               if (ch_used[i] && !ch_wr_on[i] && !ch_rd_on[i]) drop_channel(i);
            end
         end
         default: o.status = ST_INVALID;
      endcase
      return o;
   endfunction

   function automatic pipe_req_t make_req(logic [2:0] op, logic [15:0] pid,
                                          logic mode, logic [7:0] h,
                                          logic [7:0] d);
      pipe_req_t r;
      r.op = op; r.pid = pid; r.mode = mode; r.handle = h; r.data_in = d;
      return r;
   endfunction

   function automatic logic [7:0] pick_handle();
      int k;
      k = $urandom_range(0, 99);
      if (k < 85) return 8'($urandom_range(3, 6));
      if (k < 95) return 8'($urandom_range(0, NCH + 4));
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_pid();
      if ($urandom_range(0, 9) < 8) return 16'($urandom_range(1, 6));
      return 16'($urandom);
   endfunction

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= idle_pct))
         begin
            pipe_req_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(channel_outcome(r));
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, r.data_in, r.handle, r.mode, r.pid};
            req_tuser <= r.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && (quiet_phase || $urandom_range(0, 99) >= idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            pipe_rsp_t got, want;
            got = pipe_rsp_t'(rsp_tdata[32:0]);
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
               if (got.handle_out !== want.handle_out) begin
                  $display("%0t: handle_out expected %0d actual %0d",
                           $time, want.handle_out, got.handle_out);
                  fail_count++;
               end
               if (got.data_out !== want.data_out) begin
                  $display("%0t: data_out expected %h actual %h",
                           $time, want.data_out, got.data_out);
                  fail_count++;
               end
               if (got.wake_valid !== want.wake_valid) begin
                  $display("%0t: wake_valid expected %b actual %b",
                           $time, want.wake_valid, got.wake_valid);
                  fail_count++;
               end
               if (got.wake_pid !== want.wake_pid) begin
                  $display("%0t: wake_pid expected %h actual %h",
                           $time, want.wake_pid, got.wake_pid);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pipe_channel_manager_unit verification failed");
         $finish;
      end
   end

   // A long hold on the response side while requests keep coming.
   initial begin
      hold_rsp = 1'b0;
      wait (cycle_count > 3000);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int n, w, r;
      fail_count = 0;
      cycle_count = 0;
      stimulus_done = 0;
      quiet_phase = 1'b0;
      idle_pct = 34;
      for (int i = 0; i < NCH; i++) begin
         ch_used[i] = 0; ch_rd_on[i] = 0; ch_wr_on[i] = 0;
         ch_rd_id[i] = 0; ch_wr_id[i] = 0;
         ch_head[i] = 0; ch_tail[i] = 0; ch_fill[i] = 0;
         ch_rd_wait[i] = 0; ch_wr_wait[i] = 0;
      end
      chan_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: bad handles, empty reads, wake paths, unknown ops, table full.
      pending_reqs.push_back(make_req(OP_CLOSE, 16'h0, 0, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd255, 8'h0));
      pending_reqs.push_back(make_req(OP_OPEN, 16'hFFFF, 0, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(OP_WRITE, 16'h0, 0, 8'd3, 8'hAA));
      pending_reqs.push_back(make_req(OP_OPEN, 16'h0001, 1, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(OP_WRITE, 16'h0, 0, 8'd3, 8'hFF));
      pending_reqs.push_back(make_req(OP_WRITE, 16'h0, 0, 8'd3, 8'h00));
      pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(3'd5, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(3'd7, 16'hFFFF, 1, 8'hFF, 8'hFF));
      pending_reqs.push_back(make_req(OP_RELEASE, 16'h0001, 0, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(OP_WRITE, 16'h0, 0, 8'd3, 8'h11));
      pending_reqs.push_back(make_req(OP_CLOSE, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(OP_CLOSE, 16'h0, 0, 8'd3, 8'h0));
      for (int i = 0; i < NCH + 1; i++)
         pending_reqs.push_back(make_req(OP_OPEN, 16'(100 + i), 1, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_CLOSE, 16'h0, 0, 8'(NCH + 2), 8'h0));
      pending_reqs.push_back(make_req(OP_CLOSE, 16'h0, 0, 8'(NCH + 3), 8'h0));
      for (int i = 0; i < NCH - 1; i++)
         pending_reqs.push_back(make_req(OP_RELEASE, 16'(100 + i), 0, 8'd0, 8'h0));

      // Fill one channel past its capacity, then drain it with a writer wake.
      pending_reqs.push_back(make_req(OP_OPEN, 16'h0020, 1, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_OPEN, 16'h0021, 0, 8'd0, 8'h0));
      for (int i = 0; i < BUFB + 2; i++)
         pending_reqs.push_back(make_req(OP_WRITE, 16'h0, 0, 8'd3, 8'($urandom)));
      for (int i = 0; i < BUFB + 2; i++)
         pending_reqs.push_back(make_req(OP_READ, 16'h0, 0, 8'd3, 8'h0));
      pending_reqs.push_back(make_req(OP_RELEASE, 16'h0020, 0, 8'd0, 8'h0));
      pending_reqs.push_back(make_req(OP_RELEASE, 16'h0021, 0, 8'd0, 8'h0));

      // Random: mostly well-formed pipe sessions with random content.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            w = $urandom_range(0, 1);
            pending_reqs.push_back(make_req(OP_OPEN, pick_pid(), w[0], 8'($urandom),
                                            8'($urandom)));
            pending_reqs.push_back(make_req(OP_OPEN, pick_pid(), !w[0], 8'($urandom),
                                            8'($urandom)));
            n += 2;
            r = $urandom_range(2, 20);
            for (int k = 0; k < r; k++) begin
               pending_reqs.push_back(make_req($urandom_range(0, 9) < 5 ? OP_WRITE : OP_READ,
                                               16'($urandom), 1'($urandom), pick_handle(),
                                               8'($urandom)));
               n++;
            end
            if ($urandom_range(0, 1))
               pending_reqs.push_back(make_req(OP_CLOSE, 16'($urandom), 1'($urandom),
                                               pick_handle(), 8'($urandom)));
            else
               pending_reqs.push_back(make_req(OP_RELEASE, pick_pid(), 1'($urandom),
                                               8'($urandom), 8'($urandom)));
            n++;
         end else begin
            pending_reqs.push_back(make_req(3'($urandom), pick_pid(), 1'($urandom),
                                            pick_handle(), 8'($urandom)));
            n++;
         end
         quiet_phase = (n > RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 200);
         while (pending_reqs.size() > 30) @(posedge clock);
      end

      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (2 * NCH + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("pipe_channel_manager_unit verification clean");
      end else begin
         $display("pipe_channel_manager_unit verification failed");
      end
      $finish;
   end

endmodule
